@@ rtl/bam_pkg.sv @@
// Shared constants for the block-average mosaic unit.
package bam_pkg;

  localparam int ImageWidthDef  = 640;
  localparam int ImageHeightDef = 480;
  localparam int BlockSizeDef   = 8;

  // The block sum is always divided by 64, whatever the block size.
  localparam int AverageShift   = 6;

  localparam int PixelW         = 8;
  localparam int AverageW       = 8;
  localparam int BlockColumnW   = 7;
  localparam int BlockRowW      = 6;

  localparam logic [AverageW-1:0] AverageMax = 8'hFF;

endpackage

@@ rtl/block_average_mosaic_unit.sv @@
// Block-average mosaic unit: 8x8 (by default) block averages from a raster pixel stream.
//
// Pixels enter in raster order, one beat per clock sustained, with in_frame_start marking
// the first pixel of a frame. A line store of IMAGE_WIDTH column sums lives in one
// synchronous memory; each pixel is a read-modify-write of its column: read at accept,
// add and write back as it leaves the second stage, with the one in-flight write
// forwarded to a read of the same column. On the last row of a band, each block's column
// sums are added up, and the block's last column produces one result beat: block sum >> 6,
// saturated to 255, with the block's column and band index wrapped to 7 and 6 bits.
// The result beat is registered as the closing pixel leaves the second stage. The first
// row of every band overwrites the column sums, so the store needs no clearing pass after
// reset. Columns or rows of a partial block at the image edge are summed but never produce
// a result. The input is held back only while a result is waiting behind a stalled output
// and the pixel in flight would produce another one.
module block_average_mosaic_unit #(
  parameter int IMAGE_WIDTH  = bam_pkg::ImageWidthDef,
  parameter int IMAGE_HEIGHT = bam_pkg::ImageHeightDef,
  parameter int BLOCK_SIZE   = bam_pkg::BlockSizeDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bam_pkg::PixelW-1:0]     in_pixel,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bam_pkg::AverageW-1:0]   out_block_average,
  output logic [bam_pkg::BlockColumnW-1:0] out_block_column,
  output logic [bam_pkg::BlockRowW-1:0]  out_block_row
);

  import bam_pkg::*;

  localparam int COL_W  = $clog2(IMAGE_WIDTH);
  localparam int LINE_W = $clog2(IMAGE_HEIGHT);
  localparam int POS_W  = $clog2(BLOCK_SIZE);
  localparam int SUM_W  = $clog2(255 * BLOCK_SIZE + 1);
  localparam int ACC_W  = $clog2(255 * BLOCK_SIZE * BLOCK_SIZE + 1);

  localparam logic [COL_W-1:0]  LastCol  = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [LINE_W-1:0] LastLine = LINE_W'(IMAGE_HEIGHT - 1);
  localparam logic [POS_W-1:0]  LastPos  = POS_W'(BLOCK_SIZE - 1);

  // Position of the next pixel.
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;       // column inside the block
  logic [COL_W-1:0]  bcol_r, bcol_nxt;     // block column index
  logic [POS_W-1:0]  row_r, row_nxt;       // row inside the band
  logic [LINE_W-1:0] band_r, band_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;     // row inside the frame

  logic [COL_W-1:0]  cur_col;
  logic [POS_W-1:0]  cur_pos;
  logic [COL_W-1:0]  cur_bcol;
  logic [POS_W-1:0]  cur_row;
  logic [LINE_W-1:0] cur_band;
  logic [LINE_W-1:0] cur_line;

  // Second stage: the pixel whose column sum is being updated.
  logic              s1_valid_r;
  logic [PixelW-1:0] s1_pixel_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_first_row_r;
  logic              s1_last_row_r;
  logic              s1_first_pos_r;
  logic              s1_last_pos_r;
  logic [COL_W-1:0]  s1_bcol_r;
  logic [LINE_W-1:0] s1_band_r;
  logic              fwd_hit_r;
  logic [SUM_W-1:0]  fwd_data_r;

  logic [SUM_W-1:0]  sum_mem [IMAGE_WIDTH];
  logic [SUM_W-1:0]  rd_q;

  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic              out_valid_r;
  logic [AverageW-1:0]     out_avg_r;
  logic [BlockColumnW-1:0] out_col_r;
  logic [BlockRowW-1:0]    out_row_r;

  logic              accept;
  logic              s1_emit;
  logic              s1_adv;
  logic              out_free;
  logic [SUM_W-1:0]  s1_old;
  logic [SUM_W-1:0]  s1_sum;
  logic [ACC_W+7:0]  avg_wide;
  logic [AverageW-1:0] avg_sat;
  logic [COL_W+BlockColumnW-1:0] bcol_ext;
  logic [LINE_W+BlockRowW-1:0]   band_ext;

  assign s1_emit  = s1_last_row_r & s1_last_pos_r;
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_adv   = s1_valid_r & (~s1_emit | out_free);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;

  // Position counters, with frame start taking effect before the pixel.
  always_comb begin
    cur_col  = in_frame_start ? '0 : col_r;
    cur_pos  = in_frame_start ? '0 : pos_r;
    cur_bcol = in_frame_start ? '0 : bcol_r;
    cur_row  = in_frame_start ? '0 : row_r;
    cur_band = in_frame_start ? '0 : band_r;
    cur_line = in_frame_start ? '0 : line_r;

    col_nxt  = cur_col + COL_W'(1);
    pos_nxt  = cur_pos + POS_W'(1);
    bcol_nxt = cur_bcol;
    row_nxt  = cur_row;
    band_nxt = cur_band;
    line_nxt = cur_line;
    if (cur_pos == LastPos) begin
      pos_nxt  = '0;
      bcol_nxt = cur_bcol + COL_W'(1);
    end
    if (cur_col == LastCol) begin
      col_nxt  = '0;
      pos_nxt  = '0;
      bcol_nxt = '0;
      row_nxt  = cur_row + POS_W'(1);
      line_nxt = cur_line + LINE_W'(1);
      if (cur_row == LastPos) begin
        row_nxt  = '0;
        band_nxt = cur_band + LINE_W'(1);
      end
      if (cur_line == LastLine) begin
        row_nxt  = '0;
        band_nxt = '0;
        line_nxt = '0;
      end
    end
  end

  // Column sum update and block accumulation.
  always_comb begin
    s1_old   = fwd_hit_r ? fwd_data_r : rd_q;
    s1_sum   = s1_first_row_r ? SUM_W'(s1_pixel_r) : s1_old + SUM_W'(s1_pixel_r);
    acc_nxt  = s1_first_pos_r ? ACC_W'(s1_sum) : acc_r + ACC_W'(s1_sum);
    avg_wide = {8'd0, acc_nxt} >> AverageShift;
    avg_sat  = (avg_wide > (ACC_W + 8)'(AverageMax)) ? AverageMax : avg_wide[AverageW-1:0];
    bcol_ext = {{BlockColumnW{1'b0}}, s1_bcol_r};
    band_ext = {{BlockRowW{1'b0}}, s1_band_r};
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sum_mem[s1_col_r] <= s1_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= sum_mem[cur_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      pos_r       <= '0;
      bcol_r      <= '0;
      row_r       <= '0;
      band_r      <= '0;
      line_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (accept) begin
        col_r      <= col_nxt;
        pos_r      <= pos_nxt;
        bcol_r     <= bcol_nxt;
        row_r      <= row_nxt;
        band_r     <= band_nxt;
        line_r     <= line_nxt;
        s1_valid_r <= 1'b1;
        // The write landing at this edge is not yet visible to the read.
        fwd_hit_r  <= s1_adv & (s1_col_r == cur_col);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_last_row_r) begin
        acc_r <= acc_nxt;
      end
      if (s1_adv && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r     <= in_pixel;
      s1_col_r       <= cur_col;
      s1_first_row_r <= (cur_row == '0);
      s1_last_row_r  <= (cur_row == LastPos);
      s1_first_pos_r <= (cur_pos == '0);
      s1_last_pos_r  <= (cur_pos == LastPos);
      s1_bcol_r      <= cur_bcol;
      s1_band_r      <= cur_band;
      fwd_data_r     <= s1_sum;
    end
    if (s1_adv && s1_emit) begin
      out_avg_r <= avg_sat;
      out_col_r <= bcol_ext[BlockColumnW-1:0];
      out_row_r <= band_ext[BlockRowW-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_average = out_avg_r;
  assign out_block_column  = out_col_r;
  assign out_block_row     = out_row_r;

endmodule
